// ----- rtl/core/dcnf_pkg.sv -----
// Shared types and defaults for the dual-channel notch filter.
package dcnf_pkg;

  localparam int SampleWidthDef  = 16;
  localparam int CoefFracBitsDef = 16;
  localparam int CfgIdxW         = 2;

  // Coefficient register indexes on the write port
  typedef enum logic [CfgIdxW-1:0] {
    REG_B0 = 2'd0,
    REG_B1 = 2'd1,
    REG_A1 = 2'd2,
    REG_A2 = 2'd3
  } cfg_reg_e;

  // Per-lane pipeline strobes from the merge/control stage
  typedef struct packed {
    logic s1_load;  // accept a new sample into the feed-forward stage
    logic s2_load;  // retire the feedback result into the y history and output register
  } lane_ctrl_t;

endpackage

// ----- rtl/core/dcnf_if.sv -----
// Handshake interfaces for the sample and result channels.
interface dcnf_smp_if #(
  parameter int SampleWidth = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] d_current;
  logic signed [SampleWidth-1:0] q_current;

  modport source (output valid, output d_current, output q_current, input ready);
  modport sink   (input valid, input d_current, input q_current, output ready);
endinterface

interface dcnf_res_if #(
  parameter int SampleWidth = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] d_filtered;
  logic signed [SampleWidth-1:0] q_filtered;

  modport source (output valid, output d_filtered, output q_filtered, input ready);
  modport sink   (input valid, input d_filtered, input q_filtered, output ready);
endinterface

// ----- rtl/core/dcnf_lane.sv -----
// One notch lane: feed-forward stage, feedback stage and its sample histories.
module dcnf_lane #(
  parameter int SampleWidth  = 16,
  parameter int CoefFracBits = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dcnf_pkg::lane_ctrl_t            ctrl_i,
  input  logic signed [SampleWidth-1:0]   x_i,
  input  logic signed [CoefFracBits+1:0]  b0_i,
  input  logic signed [CoefFracBits+1:0]  b1_i,
  input  logic signed [CoefFracBits+1:0]  a1_i,
  input  logic signed [CoefFracBits+1:0]  a2_i,
  output logic signed [SampleWidth-1:0]   y_o
);
  import dcnf_pkg::*;

  localparam int CoefW = CoefFracBits + 2;
  localparam int ProdW = CoefW + SampleWidth + 1;
  localparam int AccW  = CoefW + SampleWidth + 2;

  localparam logic signed [AccW-1:0] RndHalf =
    {{(AccW-1){1'b0}}, 1'b1} << (CoefFracBits - 1);
  localparam logic signed [AccW-1:0] YMax =
    {{(AccW-SampleWidth+1){1'b0}}, {(SampleWidth-1){1'b1}}};
  localparam logic signed [AccW-1:0] YMin =
    {{(AccW-SampleWidth+1){1'b1}}, {(SampleWidth-1){1'b0}}};

  // x[n-1], x[n-2] and y[n-1], y[n-2]
  logic signed [SampleWidth-1:0] xh0_q, xh1_q, yh0_q, yh1_q;
  logic signed [AccW-1:0]        ff_q, ff_d;

  logic signed [SampleWidth:0]   xsum;
  logic signed [ProdW-1:0]       p_b0, p_b1;
  logic signed [ProdW-2:0]       p_a1, p_a2;
  logic signed [AccW-1:0]        acc, shifted;

  // Feed-forward part, independent of the recursion
  always_comb begin
    xsum = {x_i[SampleWidth-1], x_i} + {xh1_q[SampleWidth-1], xh1_q};
    p_b0 = b0_i * xsum;
    p_b1 = ProdW'(b1_i * xh0_q);
    ff_d = AccW'(p_b0) + AccW'(p_b1);
  end

  // Recursive part: one multiply level, sum, round and clamp
  always_comb begin
    p_a1    = a1_i * yh0_q;
    p_a2    = a2_i * yh1_q;
    acc     = ff_q - AccW'(p_a1) - AccW'(p_a2) + RndHalf;
    shifted = acc >>> CoefFracBits;
    if (shifted > YMax) begin
      y_o = YMax[SampleWidth-1:0];
    end else if (shifted < YMin) begin
      y_o = YMin[SampleWidth-1:0];
    end else begin
      y_o = shifted[SampleWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh0_q <= '0;
      xh1_q <= '0;
      yh0_q <= '0;
      yh1_q <= '0;
    end else begin
      if (ctrl_i.s1_load) begin
        xh0_q <= x_i;
        xh1_q <= xh0_q;
      end
      if (ctrl_i.s2_load) begin
        yh0_q <= y_o;
        yh1_q <= yh0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      ff_q <= ff_d;
    end
  end

endmodule

// ----- rtl/core/dual_channel_notch_filter_core.sv -----
// Top level: coefficient registers, d and q lanes, merged output word register.
//
// Two second-order notch filters, one on the d-axis and one on the q-axis
// current, run side by side as identical lanes and share four Q2.16
// coefficients (b0, b1, a1, a2) set through the write port; after reset
// b0 = 1.0 and the others are zero, so y = x[n] + x[n-2]. A new sample word
// is taken every clock cycle while the pipeline is not stalled. The products
// b0*(x[n]+x[n-2]) + b1*x[n-1] are registered in the feed-forward stage; the
// recursive terms a1*y[n-1] and a2*y[n-2], rounding to nearest (ties upward)
// and saturation follow it into the output register. The recursion through
// y[n-1] closes in the output stage, so it is the path that sets the clock.
// The two lane results land together in a single output register; while it
// is stalled the pipeline holds, and an empty front stage can still take one
// more word. Coefficients may be changed only while no word is in flight.
module dual_channel_notch_filter_core #(
  parameter int SampleWidth  = dcnf_pkg::SampleWidthDef,
  parameter int CoefFracBits = dcnf_pkg::CoefFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcnf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoefFracBits+1:0]       cfg_wdata_i,
  dcnf_smp_if.sink                      smp_i,
  dcnf_res_if.source                    res_o
);
  import dcnf_pkg::*;

  localparam int CoefW = CoefFracBits + 2;
  localparam logic signed [CoefW-1:0] CoefOne = {{(CoefW-1){1'b0}}, 1'b1} << CoefFracBits;

  logic signed [CoefW-1:0] b0_q, b1_q, a1_q, a2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= CoefOne;
      b1_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_B0:  b0_q <= cfg_wdata_i;
        REG_B1:  b1_q <= cfg_wdata_i;
        REG_A1:  a1_q <= cfg_wdata_i;
        REG_A2:  a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic       s1_vld_q, out_vld_q;
  logic       out_en, s1_en, s1_load;
  lane_ctrl_t lane_ctrl;

  assign out_en    = !out_vld_q || res_o.ready;
  assign s1_en     = !s1_vld_q || out_en;
  assign s1_load   = smp_i.valid && s1_en;
  assign smp_i.ready = s1_en;

  assign lane_ctrl.s1_load = s1_load;
  assign lane_ctrl.s2_load = s1_vld_q && out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_q <= smp_i.valid;
      end
      if (out_en) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  logic signed [SampleWidth-1:0] d_y, q_y;

  dcnf_lane #(
    .SampleWidth  (SampleWidth),
    .CoefFracBits (CoefFracBits)
  ) u_lane_d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lane_ctrl),
    .x_i    (smp_i.d_current),
    .b0_i   (b0_q),
    .b1_i   (b1_q),
    .a1_i   (a1_q),
    .a2_i   (a2_q),
    .y_o    (d_y)
  );

  dcnf_lane #(
    .SampleWidth  (SampleWidth),
    .CoefFracBits (CoefFracBits)
  ) u_lane_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lane_ctrl),
    .x_i    (smp_i.q_current),
    .b0_i   (b0_q),
    .b1_i   (b1_q),
    .a1_i   (a1_q),
    .a2_i   (a2_q),
    .y_o    (q_y)
  );

  // Merged output word
  logic signed [SampleWidth-1:0] d_out_q, q_out_q;

  always_ff @(posedge clk_i) begin
    if (lane_ctrl.s2_load) begin
      d_out_q <= d_y;
      q_out_q <= q_y;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.d_filtered = d_out_q;
  assign res_o.q_filtered = q_out_q;

endmodule

// ----- tb/dual_channel_notch_filter_core_test.sv -----
// Self-checking testbench for the dual-channel notch filter core.
module dual_channel_notch_filter_core_test;
  import dcnf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW        = SampleWidthDef;
  localparam int FB        = CoefFracBitsDef;
  localparam int CW        = CoefFracBitsDef + 2;
  localparam int MaxCycles = 300000;
  localparam int HoldLen   = 80;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [CW-1:0]        coef_t;

  typedef struct {
    sample_t d;
    sample_t q;
  } filt_word_t;

  // Keeps its own copy of the coefficients and per-lane histories (lane 0 = d, 1 = q)
  class notch_checker;
    longint b0, b1, a1, a2;
    longint x_prev1[2], x_prev2[2], y_prev1[2], y_prev2[2];
    filt_word_t expected_words[$];
    int mismatch_cnt;

    function new();
      b0 = longint'(1) << FB;
      b1 = 0;
      a1 = 0;
      a2 = 0;
      for (int l = 0; l < 2; l++) begin
        x_prev1[l] = 0;
        x_prev2[l] = 0;
        y_prev1[l] = 0;
        y_prev2[l] = 0;
      end
      mismatch_cnt = 0;
    endfunction

    function void set_coef(cfg_reg_e r, coef_t v);
      longint sv;
      sv = longint'($signed(v));
      case (r)
        REG_B0: b0 = sv;
        REG_B1: b1 = sv;
        REG_A1: a1 = sv;
        REG_A2: a2 = sv;
        default: ;
      endcase
    endfunction

    function sample_t filter_lane(int l, sample_t x);
      longint acc, y, hi, lo;
      hi = (longint'(1) << (SW - 1)) - 1;
      lo = -hi - 1;
      acc = b0 * (longint'(x) + x_prev2[l]) + b1 * x_prev1[l]
          - a1 * y_prev1[l] - a2 * y_prev2[l];
      // add one half then floor: ties go upward
      y = (acc + (longint'(1) << (FB - 1))) >>> FB;
      if (y > hi) y = hi;
      if (y < lo) y = lo;
      x_prev2[l] = x_prev1[l];
      x_prev1[l] = longint'(x);
      y_prev2[l] = y_prev1[l];
      y_prev1[l] = y;
      return sample_t'(y);
    endfunction

    function void note_sample(sample_t d, sample_t q);
      filt_word_t w;
      w.d = filter_lane(0, d);
      w.q = filter_lane(1, q);
      expected_words.push_back(w);
    endfunction

    function void report(string field, sample_t exp_v, sample_t act_v);
      mismatch_cnt++;
      if (mismatch_cnt <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_result(sample_t d, sample_t q);
      filt_word_t w;
      if (expected_words.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
          $display("%0t: unexpected result word, expected none, got d=%0d q=%0d",
                   $time, d, q);
        return;
      end
      w = expected_words.pop_front();
      if (d !== w.d) report("d_filtered", w.d, d);
      if (q !== w.q) report("q_filtered", w.q, q);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  coef_t             cfg_wdata_i;

  dcnf_smp_if #(.SampleWidth(SW)) smp ();
  dcnf_res_if #(.SampleWidth(SW)) res ();

  dual_channel_notch_filter_core #(
    .SampleWidth (SW),
    .CoefFracBits(FB)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .smp_i      (smp),
    .res_o      (res)
  );

  notch_checker chk;
  int           cycle_cnt;
  bit           hold_req;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < MaxCycles) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // Monitors: all sample pre-edge values at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) chk.set_coef(cfg_reg_e'(cfg_idx_i), cfg_wdata_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && smp.valid && smp.ready) chk.note_sample(smp.d_current, smp.q_current);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) chk.check_result(res.d_filtered, res.q_filtered);
  end

  // Receiver: a stall pattern drawn at random from four modes; a hold request forces a long stall
  initial begin
    int stall_mode;
    int mode_cnt;
    int hold_cnt;
    res.ready  = 1'b0;
    stall_mode = 0;
    mode_cnt   = 0;
    hold_cnt   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HoldLen;
      end
      mode_cnt++;
      if (mode_cnt == 64) begin
        mode_cnt   = 0;
        stall_mode = $urandom_range(0, 3);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= ($urandom_range(0, 3) != 0);
          2:       res.ready <= (mode_cnt[2:1] != 2'b11);
          default: res.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'($urandom_range(0, 3) == 0 ? 16'h7fff :
                                $urandom_range(0, 2) == 0 ? 16'h8000 :
                                $urandom_range(0, 1) ? 16'hffff : 16'h0000);
      1, 2:    return sample_t'($signed($urandom_range(0, 600)) - 300);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 5))
      0:       return coef_t'($urandom_range(0, 1) ? 18'h1ffff : 18'h20000);
      1, 2:    return coef_t'($signed($urandom_range(0, 131072)) - 65536);
      default: return coef_t'($urandom());
    endcase
  endfunction

  // Offers one word and holds it until the block takes it
  task automatic push_sample(input sample_t d, input sample_t q);
    smp.valid     <= 1'b1;
    smp.d_current <= d;
    smp.q_current <= q;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  // Stops offering, then waits for every expected word and the pipeline to settle
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t a1,
                            input coef_t a2);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_B0;
    cfg_wdata_i <= b0;
    @(posedge clk_i);
    cfg_idx_i   <= REG_B1;
    cfg_wdata_i <= b1;
    @(posedge clk_i);
    cfg_idx_i   <= REG_A1;
    cfg_wdata_i <= a1;
    @(posedge clk_i);
    cfg_idx_i   <= REG_A2;
    cfg_wdata_i <= a2;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input bit gappy);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 16);
      for (int j = 0; j < burst && sent < n; j++) begin
        push_sample(rand_sample(), rand_sample());
        sent++;
      end
      gap = gappy ? $urandom_range(0, 6) : 0;
      if (gap > 0 && sent < n) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    chk           = new();
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_B0;
    cfg_wdata_i   = '0;
    smp.valid     = 1'b0;
    smp.d_current = '0;
    smp.q_current = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients: y = x[n] + x[n-2], so repeated extremes saturate both ways
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sh7fff, -16'sh8000);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sh7fff, -16'sh8000);
    push_sample(-16'sh8000, 16'sh7fff);
    push_sample(-16'sd1, 16'sd1);
    push_sample(-16'sh8000, 16'sh7fff);
    drain();

    // b0 = 0.5: odd samples land exactly on a half, both signs
    load_coefs(18'h08000, 18'h0, 18'h0, 18'h0);
    push_sample(16'sd1, -16'sd1);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd3, -16'sd3);
    push_sample(16'sd0, 16'sd0);
    drain();

    // Extreme coefficients: clamped outputs fed back
    load_coefs(18'h20000, 18'h1ffff, 18'h20000, 18'h1ffff);
    push_sample(16'sh7fff, -16'sh8000);
    push_sample(-16'sh8000, 16'sh7fff);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(-16'sh8000, -16'sh8000);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sd12345, -16'sd12345);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       load_coefs(18'h1ffff, 18'h1ffff, 18'h1ffff, 18'h1ffff);
        1:       load_coefs(18'h20000, 18'h20000, 18'h20000, 18'h20000);
        2:       load_coefs(18'h0, 18'h0, 18'h0, 18'h0);
        // typical stable notch: b0 ~ 0.95, a2 ~ 0.9
        4:       load_coefs(18'd62259, coef_t'(-18'sd100000), coef_t'(-18'sd95000), 18'd58982);
        default: load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      if (p == 3) begin
        hold_req = 1'b1;
        run_random(116, 1'b0);
      end else begin
        run_random(116, ($urandom_range(0, 3) != 0));
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (chk.mismatch_cnt == 0 && chk.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
